// ----- hdl/bf3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned COL_SUM_W = 10;

  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd512;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd512;

  // Reciprocal of 9 scaled by 2^23, rounded up; exact for dividends below 2^20.
  localparam int unsigned SCALE_IN_W = SUM_W + 8;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [SCALE_IN_W-1:0] RECIP_NINE = 20'd932068;
  localparam logic [SCALE_IN_W-1:0] ROUND_BIAS = 20'd4;

  localparam logic [VAL_W-1:0] VAL_MAX = 16'hFF00;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] newer;
  } row_pair_t;

endpackage : bf3_pkg
`default_nettype wire

// ----- hdl/bf3_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_ram
// Simple dual-port RAM, one write and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bf3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : bf3_ram
`default_nettype wire

// ----- hdl/bf3_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_scale
// Nine-pixel sum to Q8.8 mean: round(sum * 256 / 9) by reciprocal multiply.
// ----------------------------------------------------------------------------
module bf3_scale
  import bf3_pkg::*;
(
  input  wire logic [SUM_W-1:0] sum_i,
  output logic      [VAL_W-1:0] value_o
);

  logic [SCALE_IN_W-1:0]   dividend;
  logic [2*SCALE_IN_W-1:0] product;

  assign dividend = {sum_i, 8'h00} + ROUND_BIAS;
  assign product  = dividend * RECIP_NINE;
  assign value_o  = product[RECIP_SHIFT +: VAL_W];

endmodule : bf3_scale
`default_nettype wire

// ----- hdl/box_filter_3x3_replicate_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate_top
// 3x3 mean filter with replicated borders on a raster pixel stream.
//
// Pixels enter on the s_axis port, one 8-bit word per handshake, in raster
// order of an image_width x image_height frame. Results leave on m_axis as
// Q8.8 means; tlast marks the last result caused by one input pixel, tuser
// the last result of the frame. Pixels in the first row, and the first
// column of later rows, cause no result; the last column and the last row
// add extra results, up to four for the final pixel of the frame.
// Throughput: one pixel per clock while each pixel causes at most one
// result and m_axis does not stall; each further result of a pixel holds
// the input back while it is sent. A result passes the stage one register
// (row store read), the result slots (window and sums) and the output register.
// The two row stores share one RAM read and written once per pixel.
// Writing either size register restarts the frame at pixel (0, 0).
// Reset clears the counters and pipeline; sizes return to 512 x 512.
// When m_axis stalls, the pipeline holds and s_axis_tready drops once stage
// one holds a pixel and the result slots behind the output register are busy.
// ----------------------------------------------------------------------------
module box_filter_3x3_replicate_top
  import bf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  // pixel in
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [7:0] pixel
  // result out
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [15:0]      m_axis_tdata,   // [15:0] filtered_value
  output logic                  m_axis_tlast,
  output logic      [0:0]       m_axis_tuser    // [0] frame_last
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WMW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW   = (WMW > CFG_W) ? WMW : CFG_W;
  localparam int unsigned NRES = 4;

  // configuration
  logic [CFG_W-1:0] width_q, height_q;
  logic [LW-1:0]    width_ext, w_eff;
  logic [CFG_W-1:0] h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_ext = LW'(width_q);

  always_comb begin
    w_eff = width_ext;
    if (width_ext == '0) begin
      w_eff = LW'(1);
    end else if (width_ext > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end
    h_eff = height_q;
    if (height_q == '0) begin
      h_eff = CFG_W'(1);
    end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end
  end

  // position of the next pixel
  logic [AW-1:0]    col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic             wrap, last_col, last_row;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign wrap   = (LW'(col_q) >= w_eff) || (CFG_W'(row_q) >= h_eff);

  always_comb begin
    col_cur  = wrap ? '0 : col_q;
    row_cur  = wrap ? '0 : row_q;
    last_col = (LW'(col_cur) == (w_eff - LW'(1)));
    last_row = (CFG_W'(row_cur) == (h_eff - CFG_W'(1)));
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_d = col_cur + AW'(1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: row store read data
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [AW-1:0]    s1_col_q;
  logic             s1_first_row_q, s1_first_col_q, s1_last_col_q, s1_last_row_q;
  logic             s1_fwd_q;
  row_pair_t        fwd_data_q;
  row_pair_t        ram_rdata, rd_pair, wr_pair;
  logic             s1_adv, bundle_free;

  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s1_adv        = s1_valid_q && bundle_free;

  bf3_ram #(
    .WIDTH ($bits(row_pair_t)),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (wr_pair),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  assign rd_pair       = s1_fwd_q ? fwd_data_q : ram_rdata;
  assign wr_pair.older = s1_first_row_q ? s1_pix_q : rd_pair.newer;
  assign wr_pair.newer = s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q       <= s_axis_tdata;
      s1_col_q       <= col_cur;
      s1_first_row_q <= (row_cur == '0);
      s1_first_col_q <= (col_cur == '0);
      s1_last_col_q  <= last_col;
      s1_last_row_q  <= last_row;
      s1_fwd_q       <= s1_adv && (s1_col_q == col_cur);
      fwd_data_q     <= wr_pair;
    end
  end

  // window and sums
  win_col_t                new_col;
  win_col_t                win_q [3];
  win_col_t                win_d [3];
  logic [COL_SUM_W-1:0]    col_sum [3];
  logic [COL_SUM_W-1:0]    col_low [3];
  logic [SUM_W-1:0]        res_sum [NRES];
  logic [NRES-1:0]         res_mask;

  assign new_col.top = s1_first_row_q ? s1_pix_q : rd_pair.older;
  assign new_col.mid = s1_first_row_q ? s1_pix_q : rd_pair.newer;
  assign new_col.bot = s1_pix_q;

  always_comb begin
    if (s1_first_col_q) begin
      win_d[0] = new_col;
      win_d[1] = new_col;
    end else begin
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
    end
    win_d[2] = new_col;
    for (int i = 0; i < 3; i++) begin
      col_sum[i] = COL_SUM_W'(win_d[i].top) + COL_SUM_W'(win_d[i].mid)
                 + COL_SUM_W'(win_d[i].bot);
      col_low[i] = COL_SUM_W'(win_d[i].mid) + {1'b0, win_d[i].bot, 1'b0};
    end
    res_sum[0] = SUM_W'(col_sum[0]) + SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]);
    res_sum[1] = SUM_W'(col_sum[1]) + SUM_W'(col_sum[2]) + SUM_W'(col_sum[2]);
    res_sum[2] = SUM_W'(col_low[0]) + SUM_W'(col_low[1]) + SUM_W'(col_low[2]);
    res_sum[3] = SUM_W'(col_low[1]) + SUM_W'(col_low[2]) + SUM_W'(col_low[2]);
    res_mask[0] = !s1_first_row_q && !s1_first_col_q;
    res_mask[1] = !s1_first_row_q && s1_last_col_q;
    res_mask[2] = s1_last_row_q && !s1_first_col_q;
    res_mask[3] = s1_last_row_q && s1_last_col_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // result slots behind the output register
  logic [NRES-1:0]  b_mask_q, b_mask_rest;
  logic [SUM_W-1:0] b_sum_q [NRES];
  logic [1:0]       b_sel;
  logic             pop;
  logic [VAL_W-1:0] sel_value;

  always_comb begin
    b_sel = '0;
    for (int i = NRES - 1; i >= 0; i--) begin
      if (b_mask_q[i]) begin
        b_sel = 2'(i);
      end
    end
  end

  always_comb begin
    b_mask_rest        = b_mask_q;
    b_mask_rest[b_sel] = 1'b0;
  end

  assign pop         = (b_mask_q != '0) && (!m_axis_tvalid || m_axis_tready);
  assign bundle_free = (b_mask_q == '0) || (pop && (b_mask_rest == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_mask_q <= '0;
    end else if (s1_adv) begin
      b_mask_q <= res_mask;
    end else if (pop) begin
      b_mask_q <= b_mask_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      b_sum_q <= res_sum;
    end
  end

  bf3_scale u_scale (
    .sum_i   (b_sum_q[b_sel]),
    .value_o (sel_value)
  );

  // output register
  logic             m_valid_q;
  logic [VAL_W-1:0] m_data_q;
  logic             m_last_q, m_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (pop) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_data_q  <= sel_value;
      m_last_q  <= (b_mask_rest == '0);
      m_frame_q <= (b_sel == 2'(NRES - 1));
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tlast    = m_last_q;
  assign m_axis_tuser[0] = m_frame_q;

  // checks
  a_frame_end_closes_word : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast
  ) else $error("frame end not marked as last result of its pixel");

  a_value_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= VAL_MAX)
  ) else $error("scaled mean out of range");

  a_column_in_frame : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(accept) && !$past(cfg_we_i) |-> (LW'(col_q) < w_eff)
  ) else $error("column counter beyond row width");

  a_slots_hold_on_stall : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (b_mask_q != '0) && m_axis_tvalid && !m_axis_tready |=> $stable(b_mask_q)
  ) else $error("pending results changed while output stalled");

  a_no_advance_into_busy : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s_axis_tready |=> s1_valid_q && $stable(s1_col_q)
  ) else $error("stage one lost a pixel while stalled");

endmodule : box_filter_3x3_replicate_top
`default_nettype wire
